### rtl/rpf_pkg.sv
// Package for the remote serial protocol packet framer.
// Holds the channel structs, the queue entry type, the back-end phase enum,
// the framing characters and the hex digit function. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rpf_pkg;

	localparam int unsigned RPF_QUEUE_DEPTH = 4;

	localparam logic [7:0] CH_START = 8'h24;	// '$'
	localparam logic [7:0] CH_HASH  = 8'h23;	// '#'
	localparam logic [7:0] CH_DIGIT_ZERO = 8'h30;	// '0'
	localparam logic [7:0] CH_DIGIT_ALPHA = 8'h57;	// 'a' minus ten
	localparam logic [3:0] HEX_RADIX = 4'd10;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       first_byte;
		logic       last_byte;
		logic       empty_packet;
	} item_t;

	typedef struct packed {
		logic [7:0] frame_char;
		logic       frame_end;
	} frame_t;

	// One queued command: which parts of the frame to emit for one item.
	typedef struct packed {
		logic [7:0] ch;
		logic       start;
		logic       body;
		logic       trailer;
		logic [7:0] sum;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef enum logic [2:0] {
		PH_START,
		PH_BYTE,
		PH_HASH,
		PH_HI,
		PH_LO
	} phase_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < HEX_RADIX) begin
			return CH_DIGIT_ZERO + {4'h0, nib};
		end else begin
			return CH_DIGIT_ALPHA + {4'h0, nib};
		end
	endfunction

endpackage

`default_nettype wire

### rtl/rpf_front.sv
// Front end of the framer: accepts input transactions, keeps the running
// checksum and turns each item into a queue command. Uses rpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpf_front
	import rpf_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      item_valid,
	input  wire item_t     item,
	input  wire q_status_t q_status,
	output logic           item_stall,
	output logic           push,
	output cmd_t           cmd
);

	logic [7:0] sum_q;
	logic [7:0] sum_base;
	logic [7:0] sum_next;

	assign item_stall = q_status.full;
	assign push       = item_valid && !q_status.full;

	always_comb begin
		sum_base = (item.first_byte || item.empty_packet) ? 8'h00 : sum_q;
		sum_next = item.empty_packet ? 8'h00 : sum_base + item.payload_byte;

		cmd.ch      = item.payload_byte;
		cmd.start   = item.first_byte || item.empty_packet;
		cmd.body    = !item.empty_packet;
		cmd.trailer = item.last_byte || item.empty_packet;
		cmd.sum     = sum_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= 8'h00;
		end else if (push) begin
			sum_q <= sum_next;
		end
	end

endmodule

`default_nettype wire

### rtl/rpf_queue.sv
// Short command queue between the front and back ends of the framer.
// A ring of registers with read and write pointers. Uses rpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpf_queue
	import rpf_pkg::*;
#(
	parameter int unsigned QDEPTH = RPF_QUEUE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	input  wire logic pop,
	output cmd_t      head,
	output q_status_t q_status
);

	localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned CW = $clog2(QDEPTH + 1);

	cmd_t          entry_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		if (p == PW'(QDEPTH - 1)) begin
			return '0;
		end else begin
			return p + PW'(1);
		end
	endfunction

	assign head           = entry_q[rd_ptr_q];
	assign q_status.full  = (count_q == CW'(QDEPTH));
	assign q_status.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

### rtl/rpf_back.sv
// Back end of the framer (uses rpf_pkg): walks the phases of the queue head
// command; registers one frame character per cycle unless stalled or empty.
`timescale 1ns / 1ps
`default_nettype none

module rpf_back
	import rpf_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cmd_t      head,
	input  wire q_status_t q_status,
	output logic           pop,
	output logic           frame_valid,
	input  wire logic      frame_stall,
	output frame_t         frame
);

	phase_t phase_q;
	logic   busy_q;
	phase_t cur_phase;
	phase_t next_phase;
	logic   is_last;
	logic   load;
	logic   out_valid_q;
	frame_t out_q;
	frame_t out_next;

	always_comb begin
		if (busy_q) begin
			cur_phase = phase_q;
		end else if (head.start) begin
			cur_phase = PH_START;
		end else if (head.body) begin
			cur_phase = PH_BYTE;
		end else begin
			cur_phase = PH_HASH;
		end

		out_next.frame_end = 1'b0;
		is_last            = 1'b0;
		case (cur_phase)
			PH_START: begin
				out_next.frame_char = CH_START;
				next_phase = head.body ? PH_BYTE : PH_HASH;
			end
			PH_BYTE: begin
				out_next.frame_char = head.ch;
				next_phase = PH_HASH;
				is_last    = !head.trailer;
			end
			PH_HASH: begin
				out_next.frame_char = CH_HASH;
				next_phase = PH_HI;
			end
			PH_HI: begin
				out_next.frame_char = hex_char(head.sum[7:4]);
				next_phase = PH_LO;
			end
			PH_LO: begin
				out_next.frame_char = hex_char(head.sum[3:0]);
				out_next.frame_end  = 1'b1;
				next_phase = PH_START;
				is_last    = 1'b1;
			end
			default: begin
				out_next.frame_char = CH_HASH;
				next_phase = PH_START;
				is_last    = 1'b1;
			end
		endcase

		load = !q_status.empty && (!out_valid_q || !frame_stall);
		pop  = load && is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				phase_q <= next_phase;
				busy_q  <= !is_last;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!frame_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= out_next;
		end
	end

	assign frame_valid = out_valid_q;
	assign frame       = out_q;

endmodule

`default_nettype wire

### rtl/rsp_packet_framer.sv
// Top level of the remote serial protocol packet framer.
// Ties together rpf_front, rpf_queue and rpf_back; uses rpf_pkg.
//
// Usage: input transactions on item (valid/stall) carry one payload byte
// with first and last marks, or an empty-packet request. Output
// transactions on frame (valid/stall) carry one line character each, and
// frame_end marks the second checksum digit that closes a frame. A frame
// is '$', the payload bytes, '#', then the modulo-256 payload sum as two
// lower-case hex digits; an empty packet gives "$#00".
// An accepted item is first written into a queue entry; its first
// character is then loaded into the output register. Throughput: the back
// end emits one character per cycle while the queue holds a command and
// the receiver does not stall; a middle payload byte gives one character,
// an item with a start or a trailer up to five. The queue of
// RPF_QUEUE_DEPTH commands absorbs input while a long item drains, and
// input stalls only when that queue is full. Reset clears the checksum,
// the queue pointers and the output valid flag; no output is valid
// afterwards. When the receiver stalls, the held output stays stable, the
// back end stops, and the queue fills until the input stalls in turn.
`timescale 1ns / 1ps
`default_nettype none

module rsp_packet_framer
	import rpf_pkg::*;
#(
	parameter int unsigned QDEPTH = RPF_QUEUE_DEPTH
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_valid,
	output logic       item_stall,
	input  wire item_t item,
	output logic       frame_valid,
	input  wire logic  frame_stall,
	output frame_t     frame
);

	// Front to queue and queue status back to both ends.
	logic      push;
	cmd_t      push_cmd;
	logic      pop;
	cmd_t      head;
	q_status_t q_status;

	rpf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.q_status   (q_status),
		.item_stall (item_stall),
		.push       (push),
		.cmd        (push_cmd)
	);

	rpf_queue #(
		.QDEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.q_status (q_status)
	);

	rpf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_status    (q_status),
		.pop         (pop),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.frame       (frame)
	);

`ifndef SYNTHESIS
	// The closing character of a frame is always a hex digit.
	a_end_is_hex: assert property (@(posedge clk) disable iff (!arst_n)
		(frame_valid && frame.frame_end) |->
		((frame.frame_char >= 8'h30 && frame.frame_char <= 8'h39) ||
		 (frame.frame_char >= 8'h61 && frame.frame_char <= 8'h66)))
		else $error("frame end character is not a hex digit");

	// An accepted item into an empty queue makes the queue non-empty.
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(push && q_status.empty) |=> !q_status.empty)
		else $error("pushed command lost");

	// The back end never retires a command from an empty queue.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire
